// ===== rtl/core/tabulated_sin_cos_asin_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the tabulated sine, cosine and arcsine block
// Clocked implication checks, disabled while reset is held low.
// ----------------------------------------------------------------------------
`ifndef TABULATED_SIN_COS_ASIN_TOP_ASSERT_SVH
`define TABULATED_SIN_COS_ASIN_TOP_ASSERT_SVH

// Same-cycle implication.
`define TSCS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TSCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/tscs_pkg.sv =====
// ----------------------------------------------------------------------------
// tscs_pkg
// Shared types, fixed constants and table builders for the sine, cosine and
// arcsine evaluator.
// ----------------------------------------------------------------------------
package tscs_pkg;

    localparam int ActionWidth   = 2;
    localparam int OperandWidth  = 32;
    localparam int ResultWidth   = 18;
    localparam int InterpBits    = 16;
    localparam int ScaleFracBits = 32;

    localparam logic [31:0] HalfPiQ30    = 32'd1686629713;
    localparam logic [31:0] TwoOverPiQ32 = 32'd2734261102;

    typedef enum logic [ActionWidth-1:0] {
        ACT_SINE   = 2'd0,
        ACT_COSINE = 2'd1,
        ACT_ASIN   = 2'd2
    } t_action;

    // Per-item control carried alongside the table read.
    typedef struct packed {
        t_action act;
        logic    negate;
        logic    sat;
        logic    lo_top;
        logic    hi_top;
    } t_item_ctrl;

    function automatic logic [63:0] round_q30(input logic [63:0] v, input int fb);
        return (v + (64'd1 << (29 - fb))) >> (30 - fb);
    endfunction

    function automatic logic [63:0] half_pi_fixed(input int fb);
        return round_q30(64'(HalfPiQ30), fb);
    endfunction

    // Taylor series of sine in Q30, eight terms after the first.
    function automatic logic [63:0] sin_q30(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] acc;
        x2   = (x * x) >> 30;
        term = x;
        acc  = x;
        term = ((term * x2) >> 30) / 6;
        acc  = acc - term;
        term = ((term * x2) >> 30) / 20;
        acc  = acc + term;
        term = ((term * x2) >> 30) / 42;
        acc  = acc - term;
        term = ((term * x2) >> 30) / 72;
        acc  = acc + term;
        term = ((term * x2) >> 30) / 110;
        acc  = acc - term;
        term = ((term * x2) >> 30) / 156;
        acc  = acc + term;
        term = ((term * x2) >> 30) / 210;
        acc  = acc - term;
        term = ((term * x2) >> 30) / 272;
        acc  = acc + term;
        return acc;
    endfunction

    function automatic logic [63:0] sine_entry(input logic [63:0] idx, input int tb,
                                               input int fb);
        logic [63:0] x;
        x = (idx * 64'(HalfPiQ30)) >> tb;
        return round_q30(sin_q30(x), fb);
    endfunction

    // Largest Q30 angle whose sine does not exceed idx / 2^tb.
    function automatic logic [63:0] asin_entry(input logic [63:0] idx, input int tb,
                                               input int fb);
        logic [63:0] y;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        y   = idx << (30 - tb);
        lo  = '0;
        hi  = 64'(HalfPiQ30);
        mid = '0;
        for (int n = 0; n < 32; n++) begin
            if (lo < hi) begin
                mid = lo + ((hi - lo + 64'd1) >> 1);
                if (sin_q30(mid) <= y) begin
                    lo = mid;
                end else begin
                    hi = mid - 64'd1;
                end
            end
        end
        return round_q30(lo, fb);
    endfunction

endpackage

// ===== rtl/core/tscs_if.sv =====
// ----------------------------------------------------------------------------
// tscs_if
// Valid/ready channels: operation requests in, function results out.
// ----------------------------------------------------------------------------
interface tscs_in_if;
    logic                                     valid;
    logic                                     ready;
    logic        [tscs_pkg::ActionWidth-1:0]  action;
    logic signed [tscs_pkg::OperandWidth-1:0] operand;

    modport source (output valid, action, operand, input ready);
    modport sink   (input valid, action, operand, output ready);
endinterface

interface tscs_out_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [tscs_pkg::ResultWidth-1:0] result;
    logic                                    asin_sat;

    modport source (output valid, result, asin_sat, input ready);
    modport sink   (input valid, result, asin_sat, output ready);
endinterface

// ===== rtl/core/tscs_sine_rom.sv =====
// ----------------------------------------------------------------------------
// tscs_sine_rom
// Quarter-wave sine table, two registered read ports.
// ----------------------------------------------------------------------------
module tscs_sine_rom #(
    parameter int TABLE_BITS    = 10,
    parameter int FRACTION_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [TABLE_BITS-1:0]    i_addr_lo,
    input  logic [TABLE_BITS-1:0]    i_addr_hi,
    output logic [FRACTION_BITS:0]   o_data_lo,
    output logic [FRACTION_BITS:0]   o_data_hi
);

    localparam int Depth = 1 << TABLE_BITS;

    typedef logic [FRACTION_BITS:0] t_entry;
    typedef t_entry t_rom [Depth];

    function automatic t_rom build_rom();
        t_rom rom;
        for (int i = 0; i < Depth; i++) begin
            rom[i] = t_entry'(tscs_pkg::sine_entry(64'(i), TABLE_BITS, FRACTION_BITS));
        end
        return rom;
    endfunction

    localparam t_rom SineRom = build_rom();

    logic [FRACTION_BITS:0] r_data_lo;
    logic [FRACTION_BITS:0] r_data_hi;

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_data_lo <= SineRom[i_addr_lo];
            r_data_hi <= SineRom[i_addr_hi];
        end
    end

    assign o_data_lo = r_data_lo;
    assign o_data_hi = r_data_hi;

endmodule

// ===== rtl/core/tscs_asin_rom.sv =====
// ----------------------------------------------------------------------------
// tscs_asin_rom
// Arcsine table over [0, 1), two registered read ports.
// ----------------------------------------------------------------------------
module tscs_asin_rom #(
    parameter int TABLE_BITS    = 10,
    parameter int FRACTION_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [TABLE_BITS-1:0]    i_addr_lo,
    input  logic [TABLE_BITS-1:0]    i_addr_hi,
    output logic [FRACTION_BITS:0]   o_data_lo,
    output logic [FRACTION_BITS:0]   o_data_hi
);

    localparam int Depth = 1 << TABLE_BITS;

    typedef logic [FRACTION_BITS:0] t_entry;
    typedef t_entry t_rom [Depth];

    function automatic t_rom build_rom();
        t_rom rom;
        for (int i = 0; i < Depth; i++) begin
            rom[i] = t_entry'(tscs_pkg::asin_entry(64'(i), TABLE_BITS, FRACTION_BITS));
        end
        return rom;
    endfunction

    localparam t_rom AsinRom = build_rom();

    logic [FRACTION_BITS:0] r_data_lo;
    logic [FRACTION_BITS:0] r_data_hi;

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_data_lo <= AsinRom[i_addr_lo];
            r_data_hi <= AsinRom[i_addr_hi];
        end
    end

    assign o_data_lo = r_data_lo;
    assign o_data_hi = r_data_hi;

endmodule

// ===== rtl/core/tscs_front.sv =====
// ----------------------------------------------------------------------------
// tscs_front
// Angle scaling and arcsine magnitude (first stage), then quadrant folding
// and table address generation (second stage, alongside the table read).
// ----------------------------------------------------------------------------
module tscs_front #(
    parameter int TABLE_BITS    = 10,
    parameter int FRACTION_BITS = 16,
    parameter int WEIGHT_BITS   = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_en_a,
    input  logic                                     i_en_b,
    input  logic        [tscs_pkg::ActionWidth-1:0]  i_action,
    input  logic signed [tscs_pkg::OperandWidth-1:0] i_operand,
    output logic        [TABLE_BITS-1:0]             o_addr_lo,
    output logic        [TABLE_BITS-1:0]             o_addr_hi,
    output tscs_pkg::t_item_ctrl                     o_ctrl,
    output logic        [WEIGHT_BITS-1:0]            o_weight
);

    localparam int IB        = tscs_pkg::InterpBits;
    localparam int PhaseBits = TABLE_BITS + IB + 2;
    localparam int ShiftAmt  = FRACTION_BITS + tscs_pkg::ScaleFracBits - TABLE_BITS - IB;
    localparam int OpW       = tscs_pkg::OperandWidth;

    localparam logic [TABLE_BITS:0] TableSize = {1'b1, {TABLE_BITS{1'b0}}};

    // ---------------- first stage ----------------
    logic signed [OpW:0]                     w_scale;
    logic signed [2*OpW:0]                   w_prod;
    logic        [OpW-1:0]                   w_raw;
    logic        [OpW-1:0]                   w_mag;
    logic        [FRACTION_BITS+TABLE_BITS-1:0] w_scaled;

    logic [PhaseBits-1:0]      n_a_phase;
    tscs_pkg::t_action         n_a_act;
    logic                      n_a_neg;
    logic                      n_a_sat;
    logic [TABLE_BITS-1:0]     n_a_aidx;
    logic [FRACTION_BITS-1:0]  n_a_arem;

    logic [PhaseBits-1:0]      r_a_phase;
    tscs_pkg::t_action         r_a_act;
    logic                      r_a_neg;
    logic                      r_a_sat;
    logic [TABLE_BITS-1:0]     r_a_aidx;
    logic [FRACTION_BITS-1:0]  r_a_arem;

    assign w_scale  = {1'b0, tscs_pkg::TwoOverPiQ32};
    assign w_prod   = i_operand * w_scale;
    assign w_raw    = unsigned'(i_operand);
    assign w_mag    = i_operand[OpW-1] ? (~w_raw + {{(OpW-1){1'b0}}, 1'b1}) : w_raw;
    assign w_scaled = {w_mag[FRACTION_BITS-1:0], {TABLE_BITS{1'b0}}};

    always_comb begin
        n_a_phase = w_prod[ShiftAmt +: PhaseBits];
        n_a_act   = tscs_pkg::t_action'(i_action);
        n_a_neg   = i_operand[OpW-1];
        n_a_sat   = (n_a_act == tscs_pkg::ACT_ASIN) && (|w_mag[OpW-1:FRACTION_BITS]);
        n_a_aidx  = w_scaled[FRACTION_BITS +: TABLE_BITS];
        n_a_arem  = w_scaled[FRACTION_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en_a) begin
            r_a_phase <= n_a_phase;
            r_a_act   <= n_a_act;
            r_a_neg   <= n_a_neg;
            r_a_sat   <= n_a_sat;
            r_a_aidx  <= n_a_aidx;
            r_a_arem  <= n_a_arem;
        end
    end

    // ---------------- second stage ----------------
    logic [1:0]             w_quad;
    logic [TABLE_BITS-1:0]  w_sidx;
    logic [IB-1:0]          w_srem;
    logic [TABLE_BITS:0]    w_slo;
    logic [IB-1:0]          w_sw;
    logic [TABLE_BITS:0]    w_lo;
    logic [TABLE_BITS:0]    w_hi;

    tscs_pkg::t_item_ctrl   n_b_ctrl;
    logic [WEIGHT_BITS-1:0] n_b_weight;
    tscs_pkg::t_item_ctrl   r_b_ctrl;
    logic [WEIGHT_BITS-1:0] r_b_weight;

    always_comb begin
        w_quad = r_a_phase[PhaseBits-1 -: 2]
               + {1'b0, (r_a_act == tscs_pkg::ACT_COSINE)};
        w_sidx = r_a_phase[IB +: TABLE_BITS];
        w_srem = r_a_phase[IB-1:0];

        // Mirror odd quadrants; a zero fraction lands exactly on an entry.
        if (w_quad[0]) begin
            if (w_srem == '0) begin
                w_slo = TableSize - {1'b0, w_sidx};
                w_sw  = '0;
            end else begin
                w_slo = TableSize - {1'b0, w_sidx} - {{TABLE_BITS{1'b0}}, 1'b1};
                w_sw  = '0 - w_srem;
            end
        end else begin
            w_slo = {1'b0, w_sidx};
            w_sw  = w_srem;
        end

        n_b_ctrl.act    = r_a_act;
        n_b_ctrl.sat    = r_a_sat;
        n_b_ctrl.negate = 1'b0;
        w_lo            = w_slo;
        n_b_weight      = WEIGHT_BITS'(w_sw) << (WEIGHT_BITS - IB);

        unique case (r_a_act)
            tscs_pkg::ACT_SINE, tscs_pkg::ACT_COSINE: begin
                n_b_ctrl.negate = w_quad[1];
            end
            tscs_pkg::ACT_ASIN: begin
                n_b_ctrl.negate = r_a_neg;
                w_lo            = {1'b0, r_a_aidx};
                n_b_weight      = WEIGHT_BITS'(r_a_arem) << (WEIGHT_BITS - FRACTION_BITS);
            end
            default: begin
                n_b_ctrl.negate = 1'b0;
            end
        endcase

        w_hi            = w_lo + {{TABLE_BITS{1'b0}}, 1'b1};
        n_b_ctrl.lo_top = w_lo[TABLE_BITS];
        n_b_ctrl.hi_top = w_hi[TABLE_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (i_en_b) begin
            r_b_ctrl   <= n_b_ctrl;
            r_b_weight <= n_b_weight;
        end
    end

    assign o_addr_lo = w_lo[TABLE_BITS-1:0];
    assign o_addr_hi = w_hi[TABLE_BITS-1:0];
    assign o_ctrl    = r_b_ctrl;
    assign o_weight  = r_b_weight;

endmodule

// ===== rtl/core/tscs_interp.sv =====
// ----------------------------------------------------------------------------
// tscs_interp
// Linear interpolation between two table samples: weighted products, then
// rounding, saturation override and sign.
// ----------------------------------------------------------------------------
module tscs_interp #(
    parameter int FRACTION_BITS = 16,
    parameter int WEIGHT_BITS   = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_en_c,
    input  logic                                    i_en_d,
    input  tscs_pkg::t_item_ctrl                    i_ctrl,
    input  logic        [WEIGHT_BITS-1:0]           i_weight,
    input  logic        [FRACTION_BITS:0]           i_sin_lo,
    input  logic        [FRACTION_BITS:0]           i_sin_hi,
    input  logic        [FRACTION_BITS:0]           i_asin_lo,
    input  logic        [FRACTION_BITS:0]           i_asin_hi,
    output logic signed [tscs_pkg::ResultWidth-1:0] o_result,
    output logic                                    o_asin_sat
);

    localparam int ValueBits = FRACTION_BITS + 1;
    localparam int ProdBits  = ValueBits + WEIGHT_BITS + 1;
    localparam int RW        = tscs_pkg::ResultWidth;
    localparam int WideBits  = (ValueBits > RW) ? ValueBits : RW;

    localparam logic [FRACTION_BITS:0] OneFix    = {1'b1, {FRACTION_BITS{1'b0}}};
    localparam logic [FRACTION_BITS:0] HalfPiFix =
        ValueBits'(tscs_pkg::half_pi_fixed(FRACTION_BITS));
    localparam logic [WEIGHT_BITS:0]   WeightOne = {1'b1, {WEIGHT_BITS{1'b0}}};
    localparam logic [ProdBits-1:0]    RoundHalf = ProdBits'(1) << (WEIGHT_BITS - 1);

    // ---------------- products ----------------
    logic [FRACTION_BITS:0] w_a;
    logic [FRACTION_BITS:0] w_b;
    logic [WEIGHT_BITS:0]   w_wlo;

    logic [ProdBits-1:0]    n_c_plo;
    logic [ProdBits-1:0]    n_c_phi;
    tscs_pkg::t_item_ctrl   r_c_ctrl;
    logic [ProdBits-1:0]    r_c_plo;
    logic [ProdBits-1:0]    r_c_phi;

    always_comb begin
        // Samples past the last entry are the fixed end points.
        if (i_ctrl.act == tscs_pkg::ACT_ASIN) begin
            w_a = i_ctrl.lo_top ? HalfPiFix : i_asin_lo;
            w_b = i_ctrl.hi_top ? HalfPiFix : i_asin_hi;
        end else begin
            w_a = i_ctrl.lo_top ? OneFix : i_sin_lo;
            w_b = i_ctrl.hi_top ? OneFix : i_sin_hi;
        end
        w_wlo   = WeightOne - {1'b0, i_weight};
        n_c_plo = ProdBits'(w_a) * ProdBits'(w_wlo);
        n_c_phi = ProdBits'(w_b) * ProdBits'(i_weight);
    end

    always_ff @(posedge i_clk) begin
        if (i_en_c) begin
            r_c_ctrl <= i_ctrl;
            r_c_plo  <= n_c_plo;
            r_c_phi  <= n_c_phi;
        end
    end

    // ---------------- round, override, sign ----------------
    logic [ProdBits-1:0]    w_sum;
    logic [FRACTION_BITS:0] w_val;
    logic [FRACTION_BITS:0] w_mag;
    logic [WideBits-1:0]    w_wide;
    logic [RW-1:0]          w_mag_res;
    logic [RW-1:0]          n_d_result;
    logic [RW-1:0]          r_d_result;
    logic                   r_d_flag;

    always_comb begin
        w_sum = r_c_plo + r_c_phi + RoundHalf;
        w_val = w_sum[WEIGHT_BITS +: ValueBits];

        unique case (r_c_ctrl.act)
            tscs_pkg::ACT_SINE, tscs_pkg::ACT_COSINE: w_mag = w_val;
            tscs_pkg::ACT_ASIN: w_mag = r_c_ctrl.sat ? HalfPiFix : w_val;
            default:            w_mag = '0;
        endcase

        w_wide     = WideBits'(w_mag);
        w_mag_res  = w_wide[RW-1:0];
        n_d_result = r_c_ctrl.negate ? (RW'(0) - w_mag_res) : w_mag_res;
    end

    always_ff @(posedge i_clk) begin
        if (i_en_d) begin
            r_d_result <= n_d_result;
            r_d_flag   <= r_c_ctrl.sat;
        end
    end

    assign o_result   = signed'(r_d_result);
    assign o_asin_sat = r_d_flag;

endmodule

// ===== rtl/core/tabulated_sin_cos_asin_top.sv =====
// ----------------------------------------------------------------------------
// tabulated_sin_cos_asin_top
// Sine, cosine and arcsine by linear interpolation over constant tables.
// ----------------------------------------------------------------------------
// Takes one request per cycle while the result side accepts. Each item is
// registered after each step: scale the angle (or take the arcsine
// magnitude), fold the quadrant and read two adjacent entries of each table
// through its two registered read ports, form the two weighted products,
// then round and apply the sign into the output register. Throughput is one
// item per clock while results are taken, set by the dual-port table read; a
// stall on the result side fills the bubbles first and only then holds off new
// requests. The tables are constant, so there is no load or clearing time
// after reset. Arcsine arguments of magnitude one or more return plus or
// minus pi/2 with asin_sat set.
`include "tabulated_sin_cos_asin_top_assert.svh"

module tabulated_sin_cos_asin_top #(
    parameter int TABLE_BITS    = 10,
    parameter int FRACTION_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tscs_in_if.sink           i_cmd,
    tscs_out_if.source        o_res
);

    localparam int WeightBits = (FRACTION_BITS > tscs_pkg::InterpBits) ?
                                FRACTION_BITS : tscs_pkg::InterpBits;
    localparam int RW         = tscs_pkg::ResultWidth;

    // Pipeline occupancy, one flag per stage.
    logic r_v_a;
    logic r_v_b;
    logic r_v_c;
    logic r_v_d;

    logic w_en_a;
    logic w_en_b;
    logic w_en_c;
    logic w_en_d;

    assign w_en_d = !r_v_d || o_res.ready;
    assign w_en_c = !r_v_c || w_en_d;
    assign w_en_b = !r_v_b || w_en_c;
    assign w_en_a = !r_v_a || w_en_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_a <= 1'b0;
            r_v_b <= 1'b0;
            r_v_c <= 1'b0;
            r_v_d <= 1'b0;
        end else begin
            if (w_en_a) begin
                r_v_a <= i_cmd.valid;
            end
            if (w_en_b) begin
                r_v_b <= r_v_a;
            end
            if (w_en_c) begin
                r_v_c <= r_v_b;
            end
            if (w_en_d) begin
                r_v_d <= r_v_c;
            end
        end
    end

    logic [TABLE_BITS-1:0]      w_addr_lo;
    logic [TABLE_BITS-1:0]      w_addr_hi;
    tscs_pkg::t_item_ctrl       w_ctrl;
    logic [WeightBits-1:0]      w_weight;
    logic [FRACTION_BITS:0]     w_sin_lo;
    logic [FRACTION_BITS:0]     w_sin_hi;
    logic [FRACTION_BITS:0]     w_asin_lo;
    logic [FRACTION_BITS:0]     w_asin_hi;
    logic signed [RW-1:0]       w_result;
    logic                       w_flag;

    tscs_front #(
        .TABLE_BITS    (TABLE_BITS),
        .FRACTION_BITS (FRACTION_BITS),
        .WEIGHT_BITS   (WeightBits)
    ) u_front (
        .i_clk     (i_clk),
        .i_en_a    (w_en_a),
        .i_en_b    (w_en_b),
        .i_action  (i_cmd.action),
        .i_operand (i_cmd.operand),
        .o_addr_lo (w_addr_lo),
        .o_addr_hi (w_addr_hi),
        .o_ctrl    (w_ctrl),
        .o_weight  (w_weight)
    );

    tscs_sine_rom #(
        .TABLE_BITS    (TABLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_sine_rom (
        .i_clk     (i_clk),
        .i_rd_en   (w_en_b),
        .i_addr_lo (w_addr_lo),
        .i_addr_hi (w_addr_hi),
        .o_data_lo (w_sin_lo),
        .o_data_hi (w_sin_hi)
    );

    tscs_asin_rom #(
        .TABLE_BITS    (TABLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_asin_rom (
        .i_clk     (i_clk),
        .i_rd_en   (w_en_b),
        .i_addr_lo (w_addr_lo),
        .i_addr_hi (w_addr_hi),
        .o_data_lo (w_asin_lo),
        .o_data_hi (w_asin_hi)
    );

    tscs_interp #(
        .FRACTION_BITS (FRACTION_BITS),
        .WEIGHT_BITS   (WeightBits)
    ) u_interp (
        .i_clk      (i_clk),
        .i_en_c     (w_en_c),
        .i_en_d     (w_en_d),
        .i_ctrl     (w_ctrl),
        .i_weight   (w_weight),
        .i_sin_lo   (w_sin_lo),
        .i_sin_hi   (w_sin_hi),
        .i_asin_lo  (w_asin_lo),
        .i_asin_hi  (w_asin_hi),
        .o_result   (w_result),
        .o_asin_sat (w_flag)
    );

    assign i_cmd.ready    = w_en_a;
    assign o_res.valid    = r_v_d;
    assign o_res.result   = w_result;
    assign o_res.asin_sat = w_flag;

    // ---------------- assertions ----------------
    localparam logic [RW-1:0] HalfPiRes    = RW'(tscs_pkg::half_pi_fixed(FRACTION_BITS));
    localparam logic [RW-1:0] HalfPiResNeg = RW'(0) - HalfPiRes;

    logic                       w_full;
    logic                       w_sat_out;
    logic                       w_res_half_pi;
    logic                       w_b_stall;
    logic [4*FRACTION_BITS+3:0] w_tab_data;

    assign w_full        = r_v_a && r_v_b && r_v_c && r_v_d;
    assign w_sat_out     = o_res.valid && w_flag;
    assign w_res_half_pi = (unsigned'(w_result) == HalfPiRes)
                        || (unsigned'(w_result) == HalfPiResNeg);
    assign w_b_stall     = r_v_b && !w_en_b;
    assign w_tab_data    = {w_sin_lo, w_sin_hi, w_asin_lo, w_asin_hi};

    `TSCS_ASSERT_IMPL(a_block_full, i_clk, i_rst_n, !i_cmd.ready, w_full, "stall with free stage")
    `TSCS_ASSERT_IMPL(a_sat_half_pi, i_clk, i_rst_n, w_sat_out, w_res_half_pi, "flag without pi/2")
    `TSCS_ASSERT_NEXT(a_tab_held, i_clk, i_rst_n, w_b_stall, $stable(w_tab_data), "rom data moved")

endmodule
